[hw/rtl/pid_wall_follow_steering_assert.svh]
// Assertion macros shared by the steering controller RTL.
`ifndef PID_WALL_FOLLOW_STEERING_ASSERT_SVH
`define PID_WALL_FOLLOW_STEERING_ASSERT_SVH

`ifndef SYNTHESIS
`define PWF_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pwf: assertion failed");
`define PWF_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pwf: assertion failed");
`else
`define PWF_ASSERT_IMP(name, clk, rst_n, pre, post)
`define PWF_ASSERT_NXT(name, clk, rst_n, pre, post)
`endif

`endif

[hw/rtl/pwf_pkg.sv]
`default_nettype none

package pwf_pkg;

    localparam int SENSOR_BITS   = 12;
    localparam int SUM_BITS      = 32;
    localparam int GAIN_BITS     = 24;
    localparam int FRAC_BITS     = 24;
    localparam int SPEED_BITS    = 7;
    localparam int OUT_BITS      = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam int ERR_BITS  = SENSOR_BITS + 1;
    localparam int DIFF_BITS = ERR_BITS + 1;
    localparam int PP_BITS   = GAIN_BITS + 1 + ERR_BITS;
    localparam int PD_BITS   = GAIN_BITS + 1 + DIFF_BITS;
    localparam int PI_BITS   = GAIN_BITS + 1 + SUM_BITS;
    localparam int ACC_BITS  = PI_BITS + 2;
    localparam int CTRL_BITS = ACC_BITS - FRAC_BITS;

    localparam logic [SENSOR_BITS-1:0] RST_SETPOINT  = SENSOR_BITS'(500);
    localparam logic [SENSOR_BITS-1:0] RST_FRONT_THR = SENSOR_BITS'(1000);
    localparam logic [SPEED_BITS-1:0]  RST_BASE      = SPEED_BITS'(5);
    localparam logic [SPEED_BITS-1:0]  RST_LIMIT     = SPEED_BITS'(10);
    localparam logic [GAIN_BITS-1:0]   RST_GAIN_P    = GAIN_BITS'(251658);
    localparam logic [GAIN_BITS-1:0]   RST_GAIN_I    = GAIN_BITS'(1678);
    localparam logic [GAIN_BITS-1:0]   RST_GAIN_D    = GAIN_BITS'(3355443);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SETPOINT  = 3'd0,
        CFG_FRONT_THR = 3'd1,
        CFG_BASE      = 3'd2,
        CFG_LIMIT     = 3'd3,
        CFG_GAIN_P    = 3'd4,
        CFG_GAIN_I    = 3'd5,
        CFG_GAIN_D    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [SENSOR_BITS-1:0] setpoint;
        logic [SENSOR_BITS-1:0] front_thr;
        logic [SPEED_BITS-1:0]  base;
        logic [SPEED_BITS-1:0]  limit;
        logic [GAIN_BITS-1:0]   gain_p;
        logic [GAIN_BITS-1:0]   gain_i;
        logic [GAIN_BITS-1:0]   gain_d;
    } t_cfg;

    typedef struct packed {
        logic                        avoid;
        logic signed [ERR_BITS-1:0]  err;
        logic signed [DIFF_BITS-1:0] diff;
        logic signed [SUM_BITS-1:0]  sum;
    } t_err;

endpackage

`default_nettype wire

[hw/rtl/pwf_cfg.sv]
`default_nettype none

module pwf_cfg (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [pwf_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire  [pwf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output pwf_pkg::t_cfg                      o_cfg
);
    import pwf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint  <= RST_SETPOINT;
            r_cfg.front_thr <= RST_FRONT_THR;
            r_cfg.base      <= RST_BASE;
            r_cfg.limit     <= RST_LIMIT;
            r_cfg.gain_p    <= RST_GAIN_P;
            r_cfg.gain_i    <= RST_GAIN_I;
            r_cfg.gain_d    <= RST_GAIN_D;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SETPOINT:  r_cfg.setpoint  <= i_cfg_data[SENSOR_BITS-1:0];
                CFG_FRONT_THR: r_cfg.front_thr <= i_cfg_data[SENSOR_BITS-1:0];
                CFG_BASE:      r_cfg.base      <= i_cfg_data[SPEED_BITS-1:0];
                CFG_LIMIT:     r_cfg.limit     <= i_cfg_data[SPEED_BITS-1:0];
                CFG_GAIN_P:    r_cfg.gain_p    <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_I:    r_cfg.gain_i    <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_D:    r_cfg.gain_d    <= i_cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hw/rtl/pwf_err.sv]
`default_nettype none
`include "pid_wall_follow_steering_assert.svh"

module pwf_err (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire                              i_valid,
    input  wire  [pwf_pkg::SENSOR_BITS-1:0]  i_front,
    input  wire  [pwf_pkg::SENSOR_BITS-1:0]  i_wall,
    input  pwf_pkg::t_cfg                    i_cfg,
    output logic                             o_valid,
    output pwf_pkg::t_err                    o_err
);
    import pwf_pkg::*;

    localparam int SW_BITS = SUM_BITS + 1;
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    logic signed [ERR_BITS-1:0] r_last;
    logic signed [SUM_BITS-1:0] r_sum;
    logic                       r_valid;
    t_err                       r_err;

    logic signed [ERR_BITS-1:0]  n_err;
    logic signed [DIFF_BITS-1:0] n_diff;
    logic signed [SW_BITS-1:0]   n_sum_w;
    logic signed [SUM_BITS-1:0]  n_sum;

    always_comb begin
        n_err   = $signed({1'b0, i_cfg.setpoint}) - $signed({1'b0, i_wall});
        n_diff  = DIFF_BITS'(n_err) - DIFF_BITS'(r_last);
        n_sum_w = SW_BITS'(r_sum) + SW_BITS'(n_err);
        if (n_sum_w[SW_BITS-1] != n_sum_w[SW_BITS-2]) begin
            n_sum = n_sum_w[SW_BITS-1] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = n_sum_w[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_last <= n_err;
                r_sum  <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_err.avoid <= i_front < i_cfg.front_thr;
            r_err.err   <= n_err;
            r_err.diff  <= n_diff;
            r_err.sum   <= n_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_err   = r_err;

    `PWF_ASSERT_NXT(a_state_holds, i_clk, i_rst_n, !(i_en && i_valid), $stable(r_sum) && $stable(r_last))

endmodule

`default_nettype wire

[hw/rtl/pwf_mac.sv]
`default_nettype none

module pwf_mac (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_en,
    input  wire                                    i_valid,
    input  pwf_pkg::t_err                          i_err,
    input  pwf_pkg::t_cfg                          i_cfg,
    output logic                                   o_valid,
    output logic                                   o_avoid,
    output logic signed [pwf_pkg::CTRL_BITS-1:0]   o_ctrl
);
    import pwf_pkg::*;

    logic                       r_v_prod;
    logic                       r_v_ctrl;
    logic                       r_avoid_prod;
    logic                       r_avoid_ctrl;
    logic signed [PP_BITS-1:0]  r_pp;
    logic signed [PD_BITS-1:0]  r_pd;
    logic signed [PI_BITS-1:0]  r_pi;
    logic signed [CTRL_BITS-1:0] r_ctrl;

    logic signed [PP_BITS-1:0]  n_pp;
    logic signed [PD_BITS-1:0]  n_pd;
    logic signed [PI_BITS-1:0]  n_pi;
    logic signed [ACC_BITS-1:0] n_acc;

    always_comb begin
        n_pp  = $signed({1'b0, i_cfg.gain_p}) * i_err.err;
        n_pd  = $signed({1'b0, i_cfg.gain_d}) * i_err.diff;
        n_pi  = $signed({1'b0, i_cfg.gain_i}) * i_err.sum;
        n_acc = ACC_BITS'(r_pi) + ACC_BITS'(r_pp) + ACC_BITS'(r_pd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod <= 1'b0;
            r_v_ctrl <= 1'b0;
        end else if (i_en) begin
            r_v_prod <= i_valid;
            r_v_ctrl <= r_v_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp         <= n_pp;
            r_pd         <= n_pd;
            r_pi         <= n_pi;
            r_avoid_prod <= i_err.avoid;
            // floor division by 2^24
            r_ctrl       <= n_acc[ACC_BITS-1:FRAC_BITS];
            r_avoid_ctrl <= r_avoid_prod;
        end
    end

    assign o_valid = r_v_ctrl;
    assign o_avoid = r_avoid_ctrl;
    assign o_ctrl  = r_ctrl;

endmodule

`default_nettype wire

[hw/rtl/pwf_out.sv]
`default_nettype none
`include "pid_wall_follow_steering_assert.svh"

module pwf_out (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_en,
    input  wire                                     i_valid,
    input  wire                                     i_avoid,
    input  wire  signed [pwf_pkg::CTRL_BITS-1:0]    i_ctrl,
    input  pwf_pkg::t_cfg                           i_cfg,
    output logic                                    o_valid,
    output logic signed [pwf_pkg::OUT_BITS-1:0]     o_left,
    output logic signed [pwf_pkg::OUT_BITS-1:0]     o_right,
    output logic                                    o_avoid
);
    import pwf_pkg::*;

    localparam int V_BITS = CTRL_BITS + 1;

    logic                       r_valid;
    logic signed [OUT_BITS-1:0] r_left;
    logic signed [OUT_BITS-1:0] r_right;
    logic                       r_avoid;

    logic signed [V_BITS-1:0]   n_base;
    logic signed [V_BITS-1:0]   n_lim;
    logic signed [V_BITS-1:0]   n_vl;
    logic signed [V_BITS-1:0]   n_vr;
    logic signed [OUT_BITS-1:0] n_left;
    logic signed [OUT_BITS-1:0] n_right;

    function automatic logic signed [OUT_BITS-1:0] clamp_speed(
        input logic signed [V_BITS-1:0] v,
        input logic signed [V_BITS-1:0] lim
    );
        logic signed [V_BITS-1:0] r;
        begin
            if (v > lim) begin
                r = lim;
            end else if (v < -lim) begin
                r = -lim;
            end else begin
                r = v;
            end
            return r[OUT_BITS-1:0];
        end
    endfunction

    always_comb begin
        n_base = V_BITS'($signed({1'b0, i_cfg.base}));
        n_lim  = V_BITS'($signed({1'b0, i_cfg.limit}));
        if (i_avoid) begin
            n_vl = n_base;
            n_vr = -n_base;
        end else begin
            n_vl = n_base + V_BITS'(i_ctrl);
            n_vr = n_base - V_BITS'(i_ctrl);
        end
        n_left  = clamp_speed(n_vl, n_lim);
        n_right = clamp_speed(n_vr, n_lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_avoid <= i_avoid;
        end
    end

    assign o_valid = r_valid;
    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_avoid = r_avoid;

    `PWF_ASSERT_IMP(a_avoid_mirror, i_clk, i_rst_n, r_valid && r_avoid, r_left == -r_right)
    `PWF_ASSERT_IMP(a_left_in_limit, i_clk, i_rst_n, r_valid, (r_left <= $signed({1'b0, i_cfg.limit})) && (r_left >= -$signed({1'b0, i_cfg.limit})))
    `PWF_ASSERT_IMP(a_right_in_limit, i_clk, i_rst_n, r_valid, (r_right <= $signed({1'b0, i_cfg.limit})) && (r_right >= -$signed({1'b0, i_cfg.limit})))

endmodule

`default_nettype wire

[hw/rtl/pid_wall_follow_steering.sv]
// A transaction is registered at the input, then in the error, product, sum and output stages.
// Throughput: one transaction per cycle; the whole pipeline holds while a result is stalled.
// The error/sum update is a loop through a single register; gain products and the sum are registered stages.
// Reset (synchronous, active low) clears the error state and the valid bits and
// restores the default register values.
`default_nettype none

module pid_wall_follow_steering (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [pwf_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire  [pwf_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire  [pwf_pkg::SENSOR_BITS-1:0]      i_front_distance,
    input  wire  [pwf_pkg::SENSOR_BITS-1:0]      i_wall_distance,
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic signed [pwf_pkg::OUT_BITS-1:0]  o_left_speed,
    output logic signed [pwf_pkg::OUT_BITS-1:0]  o_right_speed,
    output logic                                 o_avoiding
);
    import pwf_pkg::*;

    logic                   r_in_valid;
    logic [SENSOR_BITS-1:0] r_front;
    logic [SENSOR_BITS-1:0] r_wall;

    logic                        en;
    t_cfg                        cfg;
    logic                        err_valid;
    t_err                        err;
    logic                        ctrl_valid;
    logic                        ctrl_avoid;
    logic signed [CTRL_BITS-1:0] ctrl;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_front <= i_front_distance;
            r_wall  <= i_wall_distance;
        end
    end

    pwf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pwf_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_valid),
        .i_front (r_front),
        .i_wall  (r_wall),
        .i_cfg   (cfg),
        .o_valid (err_valid),
        .o_err   (err)
    );

    pwf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (err_valid),
        .i_err   (err),
        .i_cfg   (cfg),
        .o_valid (ctrl_valid),
        .o_avoid (ctrl_avoid),
        .o_ctrl  (ctrl)
    );

    pwf_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (ctrl_valid),
        .i_avoid (ctrl_avoid),
        .i_ctrl  (ctrl),
        .i_cfg   (cfg),
        .o_valid (o_valid),
        .o_left  (o_left_speed),
        .o_right (o_right_speed),
        .o_avoid (o_avoiding)
    );

endmodule

`default_nettype wire
